// ----- sv/tpp_pkg.sv -----
`timescale 1ns / 1ps

package tpp_pkg;

    // header layout
    localparam logic [5:0] HDR_LEN     = 6'd55;
    localparam logic [5:0] POS_SAT     = 6'd56;
    localparam logic [5:0] DASH_A      = 6'd2;
    localparam logic [5:0] DASH_B      = 6'd35;
    localparam logic [5:0] DASH_C      = 6'd52;
    localparam logic [5:0] TRACE_SPLIT = 6'd19;

    // character codes
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_LEN   = 2'd1;
    localparam logic [1:0] STATUS_BAD_DASH  = 2'd2;
    localparam logic [1:0] STATUS_BAD_VALUE = 2'd3;

    // decoded character class
    typedef struct packed {
        logic       is_dash;
        logic       is_hex;
        logic       is_zero;
        logic [3:0] nib;
    } char_info_t;

    // one result transaction
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  version;
        logic [63:0] trace_id_high;
        logic [63:0] trace_id_low;
        logic [63:0] span_id;
        logic [7:0]  flags;
        logic        sampled;
    } result_t;

endpackage

// ----- sv/traceparent_header_parser_unit.sv -----
`timescale 1ns / 1ps

// Traceparent header parser. Characters of the header value enter one per
// transaction on the char channel, the final one marked by last; one result
// transaction follows each last character, carrying a status (ok, bad length,
// bad dash count, bad field values, in that priority) and, when ok, the
// version, the 128-bit trace id in two halves, the parent id, the flags and
// the sampled bit (all zero on error). The block takes one character every
// cycle while char_stall is low; a character is held in the input register,
// then goes through the per-character update in the parser state, and a last
// character's result is written to the output register, which lets the next
// header's characters keep flowing while a result waits to be taken.
module traceparent_header_parser_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_stall,
    input  logic [7:0]  ch,
    input  logic        last,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  status,
    output logic [7:0]  version,
    output logic [63:0] trace_id_high,
    output logic [63:0] trace_id_low,
    output logic [63:0] span_id,
    output logic [7:0]  flags,
    output logic        sampled
);

    logic                s_valid_reg;
    logic                s_valid_next;
    logic [7:0]          s_ch_reg;
    logic                s_last_reg;
    logic                o_valid_reg;
    logic                o_valid_next;
    tpp_pkg::result_t    o_result_reg;
    tpp_pkg::char_info_t info;
    tpp_pkg::result_t    result;
    logic                accept;
    logic                s_adv;

    // input stage advances unless it holds a last character facing a full output
    assign s_adv      = s_valid_reg && !(s_last_reg && o_valid_reg && result_stall);
    assign char_stall = s_valid_reg && !s_adv;
    assign accept     = char_valid && !char_stall;

    always_comb
    begin
        priority if (accept)
        begin
            s_valid_next = 1'b1;
        end
        else if (s_adv)
        begin
            s_valid_next = 1'b0;
        end
        else
        begin
            s_valid_next = s_valid_reg;
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_ch_reg   <= ch;
            s_last_reg <= last;
        end
    end

    tpp_char_decode u_decode
    (
        .ch   (s_ch_reg),
        .info (info)
    );

    tpp_accum u_accum
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s_adv),
        .last   (s_last_reg),
        .info   (info),
        .result (result)
    );

    // output register control
    always_comb
    begin
        priority if (s_adv && s_last_reg)
        begin
            o_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            o_valid_next = 1'b0;
        end
        else
        begin
            o_valid_next = o_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else
        begin
            o_valid_reg <= o_valid_next;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (s_adv && s_last_reg)
        begin
            o_result_reg <= result;
        end
    end

    assign result_valid  = o_valid_reg;
    assign status        = o_result_reg.status;
    assign version       = o_result_reg.version;
    assign trace_id_high = o_result_reg.trace_id_high;
    assign trace_id_low  = o_result_reg.trace_id_low;
    assign span_id       = o_result_reg.span_id;
    assign flags         = o_result_reg.flags;
    assign sampled       = o_result_reg.sampled;

endmodule

// ----- sv/tpp_char_decode.sv -----
`timescale 1ns / 1ps

module tpp_char_decode
(
    input  logic [7:0]          ch,
    output tpp_pkg::char_info_t info
);

    logic is_digit;
    logic is_lower;
    logic is_upper;
    logic [7:0] digit_val;
    logic [7:0] lower_val;
    logic [7:0] upper_val;

    // character classes
    assign is_digit = (ch >= tpp_pkg::CHAR_ZERO) && (ch <= tpp_pkg::CHAR_NINE);
    assign is_lower = (ch >= tpp_pkg::CHAR_LO_A) && (ch <= tpp_pkg::CHAR_LO_F);
    assign is_upper = (ch >= tpp_pkg::CHAR_UP_A) && (ch <= tpp_pkg::CHAR_UP_F);

    // nibble values per class
    assign digit_val = ch - tpp_pkg::CHAR_ZERO;
    assign lower_val = ch - tpp_pkg::CHAR_LO_A + 8'd10;
    assign upper_val = ch - tpp_pkg::CHAR_UP_A + 8'd10;

    always_comb
    begin
        info.is_dash = (ch == tpp_pkg::CHAR_DASH);
        info.is_hex  = is_digit || is_lower || is_upper;
        info.is_zero = (ch == tpp_pkg::CHAR_ZERO);
        priority if (is_digit)
        begin
            info.nib = digit_val[3:0];
        end
        else if (is_lower)
        begin
            info.nib = lower_val[3:0];
        end
        else if (is_upper)
        begin
            info.nib = upper_val[3:0];
        end
        else
        begin
            info.nib = 4'd0;
        end
    end

endmodule

// ----- sv/tpp_accum.sv -----
`timescale 1ns / 1ps

module tpp_accum
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                last,
    input  tpp_pkg::char_info_t info,
    output tpp_pkg::result_t    result
);

    logic [5:0]  position_reg;
    logic [5:0]  position_next;
    logic [1:0]  dash_count_reg;
    logic [1:0]  dash_count_next;
    logic        dash_over_reg;
    logic        dash_over_next;
    logic        layout_ok_reg;
    logic        layout_ok_next;
    logic        trace_nz_reg;
    logic        trace_nz_next;
    logic        parent_nz_reg;
    logic        parent_nz_next;
    logic [7:0]  version_reg;
    logic [7:0]  version_next;
    logic [63:0] trace_hi_reg;
    logic [63:0] trace_hi_next;
    logic [63:0] trace_lo_reg;
    logic [63:0] trace_lo_next;
    logic [63:0] parent_reg;
    logic [63:0] parent_next;
    logic [7:0]  flags_reg;
    logic [7:0]  flags_next;
    logic        in_hdr;
    logic        dash_pos;

    assign in_hdr   = position_reg < tpp_pkg::HDR_LEN;
    assign dash_pos = (position_reg == tpp_pkg::DASH_A) || (position_reg == tpp_pkg::DASH_B)
                   || (position_reg == tpp_pkg::DASH_C);

    // per-character update, status on the last character
    always_comb
    begin
        position_next   = position_reg;
        dash_count_next = dash_count_reg;
        dash_over_next  = dash_over_reg;
        layout_ok_next  = layout_ok_reg;
        trace_nz_next   = trace_nz_reg;
        parent_nz_next  = parent_nz_reg;
        version_next    = version_reg;
        trace_hi_next   = trace_hi_reg;
        trace_lo_next   = trace_lo_reg;
        parent_next     = parent_reg;
        flags_next      = flags_reg;
        result          = '0;

        if (step)
        begin
            // dash counting over the whole header
            if (info.is_dash)
            begin
                if (dash_count_reg == 2'd3)
                begin
                    dash_over_next = 1'b1;
                end
                else
                begin
                    dash_count_next = dash_count_reg + 2'd1;
                end
            end

            // layout check and field shifting inside the header length
            if (in_hdr)
            begin
                if (dash_pos)
                begin
                    if (!info.is_dash)
                    begin
                        layout_ok_next = 1'b0;
                    end
                end
                else if (!info.is_hex)
                begin
                    layout_ok_next = 1'b0;
                end

                priority if (position_reg < tpp_pkg::DASH_A)
                begin
                    version_next = {version_reg[3:0], info.nib};
                end
                else if ((position_reg > tpp_pkg::DASH_A) && (position_reg < tpp_pkg::DASH_B))
                begin
                    if (!info.is_zero)
                    begin
                        trace_nz_next = 1'b1;
                    end
                    if (position_reg < tpp_pkg::TRACE_SPLIT)
                    begin
                        trace_hi_next = {trace_hi_reg[59:0], info.nib};
                    end
                    else
                    begin
                        trace_lo_next = {trace_lo_reg[59:0], info.nib};
                    end
                end
                else if ((position_reg > tpp_pkg::DASH_B) && (position_reg < tpp_pkg::DASH_C))
                begin
                    if (!info.is_zero)
                    begin
                        parent_nz_next = 1'b1;
                    end
                    parent_next = {parent_reg[59:0], info.nib};
                end
                else if (position_reg > tpp_pkg::DASH_C)
                begin
                    flags_next = {flags_reg[3:0], info.nib};
                end
                else
                begin
                    version_next = version_reg;
                end
            end

            // saturating position counter
            if (position_reg >= tpp_pkg::POS_SAT - 6'd1)
            begin
                position_next = tpp_pkg::POS_SAT;
            end
            else
            begin
                position_next = position_reg + 6'd1;
            end

            // final status and return to the idle state
            if (last)
            begin
                priority if (position_next != tpp_pkg::HDR_LEN)
                begin
                    result.status = tpp_pkg::STATUS_BAD_LEN;
                end
                else if ((dash_count_next != 2'd3) || dash_over_next)
                begin
                    result.status = tpp_pkg::STATUS_BAD_DASH;
                end
                else if (!layout_ok_next || !trace_nz_next || !parent_nz_next)
                begin
                    result.status = tpp_pkg::STATUS_BAD_VALUE;
                end
                else
                begin
                    result.status = tpp_pkg::STATUS_OK;
                end

                if (result.status == tpp_pkg::STATUS_OK)
                begin
                    result.version       = version_next;
                    result.trace_id_high = trace_hi_next;
                    result.trace_id_low  = trace_lo_next;
                    result.span_id       = parent_next;
                    result.flags         = flags_next;
                    result.sampled       = flags_next[0];
                end

                position_next   = '0;
                dash_count_next = '0;
                dash_over_next  = 1'b0;
                layout_ok_next  = 1'b1;
                trace_nz_next   = 1'b0;
                parent_nz_next  = 1'b0;
                version_next    = '0;
                trace_hi_next   = '0;
                trace_lo_next   = '0;
                parent_next     = '0;
                flags_next      = '0;
            end
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            dash_count_reg <= '0;
            dash_over_reg  <= 1'b0;
            layout_ok_reg  <= 1'b1;
            trace_nz_reg   <= 1'b0;
            parent_nz_reg  <= 1'b0;
            version_reg    <= '0;
            trace_hi_reg   <= '0;
            trace_lo_reg   <= '0;
            parent_reg     <= '0;
            flags_reg      <= '0;
        end
        else
        begin
            position_reg   <= position_next;
            dash_count_reg <= dash_count_next;
            dash_over_reg  <= dash_over_next;
            layout_ok_reg  <= layout_ok_next;
            trace_nz_reg   <= trace_nz_next;
            parent_nz_reg  <= parent_nz_next;
            version_reg    <= version_next;
            trace_hi_reg   <= trace_hi_next;
            trace_lo_reg   <= trace_lo_next;
            parent_reg     <= parent_next;
            flags_reg      <= flags_next;
        end
    end

endmodule
